// ===== rtl/core/crc8cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8cfc_pkg
// Shared types, constants and the CRC-8 byte update of the command frame
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8cfc_pkg;

  localparam int unsigned StoreDepth  = 7;
  localparam int unsigned CountWidth  = 4;
  localparam int unsigned StoreIdxW   = $clog2(StoreDepth);

  localparam logic [CountWidth-1:0] CountMax    = CountWidth'(9);
  localparam logic [CountWidth-1:0] RelativeCnt = CountWidth'(5);
  localparam logic [CountWidth-1:0] AbsoluteCnt = CountWidth'(7);
  localparam logic [CountWidth-1:0] StoreCnt    = CountWidth'(StoreDepth);

  localparam logic [7:0] CrcPoly = 8'h07;

  typedef enum logic [1:0] {
    StIgnored  = 2'd0,
    StRelative = 2'd1,
    StAbsolute = 2'd2,
    StCrcError = 2'd3
  } status_e;

  typedef logic [7:0] store_t [StoreDepth];

  typedef struct packed {
    status_e     status;
    logic [7:0]  function_code;
    logic [15:0] value_first;
    logic [15:0] value_second;
    logic [15:0] value_third;
    logic        opponent_detect_off;
    logic        realign_on;
    logic        slow_on;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc8cfc_decode.sv =====
// ----------------------------------------------------------------------------
// crc8cfc_decode
// Classifies a finished frame by length and CRC and unpacks its command
// fields from the stored bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8cfc_decode
  import crc8cfc_pkg::*;
(
  input  wire logic [CountWidth-1:0] byte_count_i,
  input  wire logic [7:0]            running_crc_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire store_t                store_i,
  output result_t                    result_o
);

  logic is_rel;
  logic is_abs;
  logic crc_ok;

  assign is_rel = (byte_count_i == RelativeCnt);
  assign is_abs = (byte_count_i == AbsoluteCnt);
  assign crc_ok = (data_byte_i == running_crc_i);

  always_comb begin
    result_o = '0;
    result_o.status = StIgnored;
    priority if (!(is_rel || is_abs)) begin
      result_o.status = StIgnored;
    end else if (!crc_ok) begin
      result_o.status = StCrcError;
    end else begin
      result_o.status              = is_abs ? StAbsolute : StRelative;
      result_o.function_code       = store_i[0];
      result_o.value_first         = {store_i[1], store_i[2]};
      result_o.value_second        = {store_i[3], store_i[4]};
      result_o.value_third         = is_abs ? {store_i[5], store_i[6]} : 16'h0000;
      result_o.opponent_detect_off = store_i[0][0];
      result_o.realign_on          = store_i[0][1];
      result_o.slow_on             = store_i[0][2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc8_command_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// crc8_command_frame_checker_core
// Checks SMBus-style CRC-8 command frames arriving one byte per request and
// reports the status and decoded fields of each frame on its last byte.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     data_byte, last_byte
//   out      output     out_valid/out_ready   frame_status, function_code,
//                                             value_first/second/third,
//                                             opponent_detect_off,
//                                             realign_on, slow_on
//
// One byte per cycle unless stalled; the CRC update and frame decode are
// combinational between the frame state registers and the result register.
// A last byte's result is registered and appears in the cycle after acceptance.
// The input stalls only while a result waits and out_ready is low.
// Reset clears byte count, CRC and result valid; stored bytes are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_command_frame_checker_core
  import crc8cfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       frame_status_o,
  output logic [7:0]       function_code_o,
  output logic [15:0]      value_first_o,
  output logic [15:0]      value_second_o,
  output logic [15:0]      value_third_o,
  output logic             opponent_detect_off_o,
  output logic             realign_on_o,
  output logic             slow_on_o
);

  logic [CountWidth-1:0] byte_count_q, byte_count_d;
  logic [7:0]            crc_q, crc_d;
  store_t                store_q;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;
  logic                  in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  crc8cfc_decode u_decode (
    .byte_count_i  (byte_count_q),
    .running_crc_i (crc_q),
    .data_byte_i   (data_byte_i),
    .store_i       (store_q),
    .result_o      (result_d)
  );

  always_comb begin
    byte_count_d = byte_count_q;
    crc_d        = crc_q;
    if (in_fire) begin
      if (last_byte_i) begin
        byte_count_d = '0;
        crc_d        = '0;
      end else begin
        crc_d = crc8_update(crc_q, data_byte_i);
        if (byte_count_q < CountMax) begin
          byte_count_d = byte_count_q + CountWidth'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !last_byte_i && (byte_count_q < StoreCnt)) begin
      store_q[byte_count_q[StoreIdxW-1:0]] <= data_byte_i;
    end
    if (in_fire && last_byte_i) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign frame_status_o        = result_q.status;
  assign function_code_o       = result_q.function_code;
  assign value_first_o         = result_q.value_first;
  assign value_second_o        = result_q.value_second;
  assign value_third_o         = result_q.value_third;
  assign opponent_detect_off_o = result_q.opponent_detect_off;
  assign realign_on_o          = result_q.realign_on;
  assign slow_on_o             = result_q.slow_on;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for crc8_command_frame_checker_core. Sends whole command frames
// byte by byte. Most frames are 6-byte relative or 8-byte absolute frames
// with a correct CRC-8. The rest have a corrupted CRC or a length the block
// ignores, including lengths that saturate the byte count. A scoreboard
// keeps its own copy of the frame state and predicts the result of each last
// byte. Each result is compared field by field with that prediction. Both
// sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc8cfc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned ItemTarget = 700;
  localparam int unsigned QuietAfter = 600;
  localparam int unsigned StallLimit = 1000;

  class frame_scoreboard;
    logic [3:0]  byte_cnt;
    logic [7:0]  crc_acc;
    logic [7:0]  kept_bytes [StoreDepth];
    result_t     expected_q[$];
    int unsigned failures;

    function new();
      byte_cnt = '0;
      crc_acc  = '0;
      failures = 0;
      foreach (kept_bytes[i]) kept_bytes[i] = '0;
    endfunction

    static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ 8'h07;
        end
      end
      return c;
    endfunction

    function void log_failure(input string msg);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void note_request(input logic [7:0] d, input logic l);
      result_t r;
      logic    is_abs;
      if (!l) begin
        if (byte_cnt < StoreCnt) begin
          kept_bytes[byte_cnt[2:0]] = d;
        end
        crc_acc = crc_step(crc_acc, d);
        if (byte_cnt < CountMax) begin
          byte_cnt++;
        end
        return;
      end
      r = '0;
      r.status = StIgnored;
      if (byte_cnt == RelativeCnt || byte_cnt == AbsoluteCnt) begin
        is_abs = (byte_cnt == AbsoluteCnt);
        if (d != crc_acc) begin
          r.status = StCrcError;
        end else begin
          r.status              = is_abs ? StAbsolute : StRelative;
          r.function_code       = kept_bytes[0];
          r.value_first         = {kept_bytes[1], kept_bytes[2]};
          r.value_second        = {kept_bytes[3], kept_bytes[4]};
          r.value_third         = is_abs ? {kept_bytes[5], kept_bytes[6]} : 16'h0000;
          r.opponent_detect_off = kept_bytes[0][0];
          r.realign_on          = kept_bytes[0][1];
          r.slow_on             = kept_bytes[0][2];
        end
      end
      expected_q.push_back(r);
      byte_cnt = '0;
      crc_acc  = '0;
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected frame result: status %0d function %h",
                              got.status, got.function_code));
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.function_code !== exp.function_code ||
          got.value_first !== exp.value_first || got.value_second !== exp.value_second ||
          got.value_third !== exp.value_third ||
          got.opponent_detect_off !== exp.opponent_detect_off ||
          got.realign_on !== exp.realign_on || got.slow_on !== exp.slow_on) begin
        log_failure($sformatf(
          "result mismatch: expected %0d %h %h %h %h %b%b%b, got %0d %h %h %h %h %b%b%b",
          exp.status, exp.function_code, exp.value_first, exp.value_second,
          exp.value_third, exp.opponent_detect_off, exp.realign_on, exp.slow_on,
          got.status, got.function_code, got.value_first, got.value_second,
          got.value_third, got.opponent_detect_off, got.realign_on, got.slow_on));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_status_o;
  logic [7:0]  function_code_o;
  logic [15:0] value_first_o;
  logic [15:0] value_second_o;
  logic [15:0] value_third_o;
  logic        opponent_detect_off_o;
  logic        realign_on_o;
  logic        slow_on_o;

  frame_scoreboard sb = new();
  int unsigned     items_sent = 0;
  bit              quiet_tail = 1'b0;
  bit              sender_calm = 1'b0;
  int unsigned     stall_cycles = 0;

  crc8_command_frame_checker_core uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .data_byte_i           (data_byte_i),
    .last_byte_i           (last_byte_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .frame_status_o        (frame_status_o),
    .function_code_o       (function_code_o),
    .value_first_o         (value_first_o),
    .value_second_o        (value_second_o),
    .value_third_o         (value_third_o),
    .opponent_detect_off_o (opponent_detect_off_o),
    .realign_on_o          (realign_on_o),
    .slow_on_o             (slow_on_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] frame_crc(input byte_q_t body);
    logic [7:0] c;
    c = 8'h00;
    foreach (body[i]) c = frame_scoreboard::crc_step(c, body[i]);
    return c;
  endfunction

  function automatic byte_q_t random_body(input int unsigned len);
    byte_q_t q;
    for (int unsigned i = 0; i < len; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    if (!quiet_tail && !sender_calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(d, l);
    items_sent++;
    if (items_sent >= QuietAfter) begin
      quiet_tail = 1'b1;
    end
  endtask

  task automatic send_frame(input byte_q_t body, input logic [7:0] tail);
    sender_calm = ($urandom_range(0, 3) == 0);
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(tail, 1'b1);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random stall bursts with calm stretches
  initial begin : result_sink
    int unsigned calm;
    result_t     got;
    calm = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm > 0) begin
        calm--;
      end else if ($urandom_range(0, 63) == 0) begin
        calm = $urandom_range(20, 200);
      end
      if (!quiet_tail && calm == 0 && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o) begin
        got.status              = status_e'(frame_status_o);
        got.function_code       = function_code_o;
        got.value_first         = value_first_o;
        got.value_second        = value_second_o;
        got.value_third         = value_third_o;
        got.opponent_detect_off = opponent_detect_off_o;
        got.realign_on          = realign_on_o;
        got.slow_on             = slow_on_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    byte_q_t     body;
    int unsigned kind;
    int unsigned len;
    bit          paused;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // relative frame, all ones
    body = random_body(0);
    repeat (5) body.push_back(8'hFF);
    send_frame(body, frame_crc(body));
    // absolute frame, all zeros
    body = random_body(0);
    repeat (7) body.push_back(8'h00);
    send_frame(body, frame_crc(body));
    // absolute frame, corrupted CRC
    body = random_body(7);
    send_frame(body, frame_crc(body) ^ 8'h80);
    // single-byte transaction
    body = random_body(0);
    send_frame(body, 8'($urandom_range(0, 255)));
    hold_until_drained();

    while (items_sent < ItemTarget) begin
      if (!paused && items_sent >= ItemTarget / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        body = random_body($urandom_range(0, 1) ? 7 : 5);
        send_frame(body, frame_crc(body));
      end else if (kind < 15) begin
        body = random_body($urandom_range(0, 1) ? 7 : 5);
        send_frame(body, frame_crc(body) ^ 8'($urandom_range(1, 255)));
      end else begin
        do begin
          len = $urandom_range(0, 13);
        end while (len == 5 || len == 7);
        body = random_body(len);
        send_frame(body, $urandom_range(0, 1) ? frame_crc(body)
                                              : 8'($urandom_range(0, 255)));
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
